>>> design/sso_pkg.sv
// ----------------------------------------------------------------------------
// sso_pkg
// Shared types and constants for the servo slew and oscillate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sso_pkg;

  localparam int unsigned AngleW = 8;
  localparam int unsigned OffW   = 7;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  // signed width for intermediate angle math (covers -360..+360)
  localparam int unsigned WideW  = 10;

  localparam logic [AngleW-1:0] MaxAngle = 8'd180;

  localparam logic [AngleW-1:0] CenterReset   = 8'd90;
  localparam logic [OffW-1:0]   FwdOffReset   = 7'd20;
  localparam logic [OffW-1:0]   LookOffReset  = 7'd60;
  localparam logic [OffW-1:0]   OscRangeReset = 7'd10;
  localparam logic [AngleW-1:0] StepReset     = 8'd2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic [CodeW-1:0] {
    TGT_FWD       = 3'd0,
    TGT_FWD_LEFT  = 3'd1,
    TGT_FWD_RIGHT = 3'd2,
    TGT_LEFT      = 3'd3,
    TGT_RIGHT     = 3'd4
  } target_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER    = 3'd0,
    CFG_FWD_OFF   = 3'd1,
    CFG_LOOK_OFF  = 3'd2,
    CFG_OSC_RANGE = 3'd3,
    CFG_STEP      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [AngleW-1:0] center;
    logic [OffW-1:0]   fwd_off;
    logic [OffW-1:0]   look_off;
    logic [OffW-1:0]   osc_range;
    logic [AngleW-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0] position;
    logic              moved;
    logic              reached_event;
    logic [CodeW-1:0]  reached_code;
  } res_t;

  function automatic logic [AngleW-1:0] clamp_angle(input logic signed [WideW-1:0] a);
    logic [AngleW-1:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > $signed({2'b00, MaxAngle})) begin
      r = MaxAngle;
    end else begin
      r = a[AngleW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/sso_cfg_regs.sv
// ----------------------------------------------------------------------------
// sso_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sso_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sso_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sso_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sso_pkg::cfg_t                     cfg_o
);
  import sso_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CENTER:    cfg_d.center    = cfg_wdata_i;
        CFG_FWD_OFF:   cfg_d.fwd_off   = cfg_wdata_i[OffW-1:0];
        CFG_LOOK_OFF:  cfg_d.look_off  = cfg_wdata_i[OffW-1:0];
        CFG_OSC_RANGE: cfg_d.osc_range = cfg_wdata_i[OffW-1:0];
        CFG_STEP:      cfg_d.step      = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center    <= CenterReset;
      cfg_q.fwd_off   <= FwdOffReset;
      cfg_q.look_off  <= LookOffReset;
      cfg_q.osc_range <= OscRangeReset;
      cfg_q.step      <= StepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/sso_step.sv
// ----------------------------------------------------------------------------
// sso_step
// Servo state registers and the per-item update: target select, slew toward
// the goal, reached event and one-degree oscillation sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module sso_step (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic                        op_i,
  input  wire logic [sso_pkg::CodeW-1:0]   sel_i,
  input  wire logic                        osc_i,
  input  wire sso_pkg::cfg_t               cfg_i,
  output sso_pkg::res_t                    res_o
);
  import sso_pkg::*;

  logic [AngleW-1:0] cur_q, cur_d;
  logic [AngleW-1:0] goal_q, goal_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic              up_q, up_d;
  logic              arr_q, arr_d;
  logic              osc_q, osc_d;

  logic [AngleW-1:0]       ctr;
  logic signed [WideW-1:0] ctr_s, cur_s, goal_s;
  logic signed [WideW-1:0] fwd_s, look_s, rng_s, lim, diff, step;
  target_e                 sel_n;
  logic [AngleW-1:0]       tgt, upper, lower;
  logic                    up_next, event_hit;

  always_comb begin
    cur_d     = cur_q;
    goal_d    = goal_q;
    code_d    = code_q;
    up_d      = up_q;
    arr_d     = arr_q;
    osc_d     = osc_q;
    step      = '0;
    event_hit = 1'b0;
    lim       = '0;
    diff      = '0;
    upper     = '0;
    lower     = '0;
    up_next   = up_q;

    ctr    = (cfg_i.center > MaxAngle) ? MaxAngle : cfg_i.center;
    ctr_s  = $signed({2'b00, ctr});
    cur_s  = $signed({2'b00, cur_q});
    goal_s = $signed({2'b00, goal_q});
    fwd_s  = $signed({3'b000, cfg_i.fwd_off});
    look_s = $signed({3'b000, cfg_i.look_off});
    rng_s  = $signed({3'b000, cfg_i.osc_range});

    // unknown codes fall back to forward
    sel_n = (sel_i > TGT_RIGHT) ? TGT_FWD : target_e'(sel_i);
    case (sel_n)
      TGT_FWD_LEFT:  tgt = clamp_angle(ctr_s + fwd_s);
      TGT_FWD_RIGHT: tgt = clamp_angle(ctr_s - fwd_s);
      TGT_LEFT:      tgt = clamp_angle(ctr_s + look_s);
      TGT_RIGHT:     tgt = clamp_angle(ctr_s - look_s);
      default:       tgt = ctr;
    endcase

    if (op_e'(op_i) == OP_SET) begin
      goal_d = tgt;
      code_d = sel_n;
      up_d   = cur_q < tgt;
      arr_d  = 1'b0;
      osc_d  = osc_i;
    end else if (!arr_q) begin
      lim  = (cfg_i.step == '0) ? WideW'(1) : $signed({2'b00, cfg_i.step});
      diff = goal_s - cur_s;
      if (up_q) begin
        step = (diff < lim) ? diff : lim;
      end else begin
        step = (diff > -lim) ? diff : -lim;
      end
      if (step == '0) begin
        arr_d     = 1'b1;
        event_hit = 1'b1;
      end
    end else if (osc_q) begin
      upper   = clamp_angle(goal_s + rng_s);
      lower   = clamp_angle(goal_s - rng_s);
      up_next = up_q ? (cur_q < upper) : (cur_q <= lower);
      up_d    = up_next;
      step    = up_next ? WideW'(1) : -WideW'(1);
    end

    if (step != '0) begin
      cur_d = clamp_angle(cur_s + step);
    end

    res_o.position      = cur_d;
    res_o.moved         = (step != '0);
    res_o.reached_event = event_hit;
    res_o.reached_code  = event_hit ? code_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= CenterReset;
      goal_q <= CenterReset;
      code_q <= TGT_FWD;
      up_q   <= 1'b1;
      arr_q  <= 1'b1;
      osc_q  <= 1'b0;
    end else if (fire_i) begin
      cur_q  <= cur_d;
      goal_q <= goal_d;
      code_q <= code_d;
      up_q   <= up_d;
      arr_q  <= arr_d;
      osc_q  <= osc_d;
    end
  end

endmodule

`default_nettype wire

>>> design/servo_slew_and_oscillate_core.sv
// ----------------------------------------------------------------------------
// servo_slew_and_oscillate_core
// Servo angle controller: set-mode items pick a look target, tick items slew
// the commanded angle toward it and then optionally sweep around it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op, target_select and
//   oscillate. Output channel (out_valid_o / out_stall_i) returns one
//   result per item: position, moved, reached_event, reached_code.
//   Items enter an input register; from there the state update and result
//   are computed and captured in the output register once it is free.
//   Throughput is one item per cycle while the receiver does not stall;
//   the input register and the result register form a two-entry pipeline.
//   When the receiver stalls, the result holds and the pipeline keeps one
//   more item in the input register; in_stall_o rises only when both are
//   full and the result is not being taken.
//   Reset clears both pipeline stages, loads the register defaults and puts
//   the servo at 90 degrees facing forward with the reached flag set, so no
//   reached event appears before the first set-mode item.
//   Configuration writes (cfg_we_i) take effect at the next edge; the user
//   must issue them only while no transaction is in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_and_oscillate_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sso_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sso_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         op_i,
  input  wire logic [sso_pkg::CodeW-1:0]    target_select_i,
  input  wire logic                         oscillate_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [sso_pkg::AngleW-1:0]        position_o,
  output logic                              moved_o,
  output logic                              reached_event_o,
  output logic [sso_pkg::CodeW-1:0]         reached_code_o
);
  import sso_pkg::*;

  cfg_t cfg;
  res_t res_comb, res_q;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_op_q;
  logic [CodeW-1:0] s1_sel_q;
  logic             s1_osc_q;
  logic             out_valid_q, out_valid_d;
  logic             res_free, fire, in_acc;

  sso_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sso_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (s1_op_q),
    .sel_i  (s1_sel_q),
    .osc_i  (s1_osc_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  assign res_free    = !out_valid_q || !out_stall_i;
  assign fire        = s1_valid_q && res_free;
  assign in_stall_o  = s1_valid_q && !res_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_acc || (s1_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= op_i;
      s1_sel_q <= target_select_i;
      s1_osc_q <= oscillate_i;
    end
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign position_o      = res_q.position;
  assign moved_o         = res_q.moved;
  assign reached_event_o = res_q.reached_event;
  assign reached_code_o  = res_q.reached_code;

endmodule

`default_nettype wire

>>> design/sso_checker.sv
// ----------------------------------------------------------------------------
// sso_checker
// Port-level checks for the servo controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sso_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         op_i,
  input wire logic [sso_pkg::CodeW-1:0]    target_select_i,
  input wire logic                         oscillate_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [sso_pkg::AngleW-1:0]   position_o,
  input wire logic                         moved_o,
  input wire logic                         reached_event_o,
  input wire logic [sso_pkg::CodeW-1:0]    reached_code_o
);
  import sso_pkg::*;

  // commanded angle never leaves the servo range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= MaxAngle))
    else $error("position out of range");

  // code is only reported together with the event
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reached_event_o) |-> (reached_code_o == '0))
    else $error("reached_code without reached_event");

  // arrival is detected on a tick that needs no move
  a_event_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reached_event_o) |-> !moved_o)
    else $error("reached_event on a moving transaction");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(position_o)
      && $stable(reached_event_o)))
    else $error("stalled result changed");

  // stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(op_i)
      && $stable(target_select_i) && $stable(oscillate_i)))
    else $error("stalled input changed");

endmodule

bind servo_slew_and_oscillate_core sso_checker u_sso_checker (.*);

`default_nettype wire

>>> tb/sv/servo_slew_and_oscillate_core_test.sv
// ----------------------------------------------------------------------------
// servo_slew_and_oscillate_core_test
// Self-checking bench for the servo slew and oscillate controller. A small
// angle tracker predicts position, move flag and reached event for every
// accepted command. Directed commands come first, then random phases under
// several register settings. Both channels idle at random, and one phase
// holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slew_and_oscillate_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sso_pkg::*;

  localparam int unsigned IdleLimit = 500;
  localparam int unsigned LongHold  = 60;

  // Predicts the controller state and keeps the results still to come.
  class angle_tracker;
    logic [AngleW-1:0] center_reg;
    logic [OffW-1:0]   fwd_off_reg;
    logic [OffW-1:0]   look_off_reg;
    logic [OffW-1:0]   range_reg;
    logic [AngleW-1:0] step_reg;
    int                cur_angle;
    int                goal_angle;
    logic [CodeW-1:0]  goal_code;
    bit                going_up;
    bit                arrived;
    bit                oscillating;
    res_t              pending_results[$];
    int                mismatches;
    int                commands;
    int                checked;
    int                events_seen;
    int                reg_writes;

    function new();
      center_reg   = CenterReset;
      fwd_off_reg  = FwdOffReset;
      look_off_reg = LookOffReset;
      range_reg    = OscRangeReset;
      step_reg     = StepReset;
      cur_angle    = int'(CenterReset);
      goal_angle   = int'(CenterReset);
      goal_code    = TGT_FWD;
      going_up     = 1'b1;
      arrived      = 1'b1;
      oscillating  = 1'b0;
      mismatches   = 0;
      commands     = 0;
      checked      = 0;
      events_seen  = 0;
      reg_writes   = 0;
    endfunction

    function int limit_angle(int a);
      if (a < 0) return 0;
      if (a > int'(MaxAngle)) return int'(MaxAngle);
      return a;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      case (idx)
        CFG_CENTER:    center_reg   = data;
        CFG_FWD_OFF:   fwd_off_reg  = data[OffW-1:0];
        CFG_LOOK_OFF:  look_off_reg = data[OffW-1:0];
        CFG_OSC_RANGE: range_reg    = data[OffW-1:0];
        CFG_STEP:      step_reg     = data;
        default: ;
      endcase
    endfunction

    function void accept_command(op_e op, logic [CodeW-1:0] sel, logic osc);
      int               c;
      int               fwd;
      int               look;
      int               stride;
      int               diff;
      int               step;
      int               upper;
      int               lower;
      logic [CodeW-1:0] code;
      bit               ev;
      res_t             r;
      step = 0;
      ev   = 1'b0;
      commands++;
      if (op == OP_SET) begin
        c    = limit_angle(int'(center_reg));
        fwd  = int'(fwd_off_reg);
        look = int'(look_off_reg);
        code = (sel > TGT_RIGHT) ? TGT_FWD : sel;
        case (code)
          TGT_FWD_LEFT:  goal_angle = limit_angle(c + fwd);
          TGT_FWD_RIGHT: goal_angle = limit_angle(c - fwd);
          TGT_LEFT:      goal_angle = limit_angle(c + look);
          TGT_RIGHT:     goal_angle = limit_angle(c - look);
          default:       goal_angle = c;
        endcase
        goal_code   = code;
        going_up    = cur_angle < goal_angle;
        arrived     = 1'b0;
        oscillating = osc;
      end else if (!arrived) begin
        stride = (step_reg == 0) ? 1 : int'(step_reg);
        diff   = goal_angle - cur_angle;
        if (going_up) begin
          step = (diff < stride) ? diff : stride;
        end else begin
          step = (diff > -stride) ? diff : -stride;
        end
        if (step == 0) begin
          arrived = 1'b1;
          ev      = 1'b1;
        end
      end else if (oscillating) begin
        upper = limit_angle(goal_angle + int'(range_reg));
        lower = limit_angle(goal_angle - int'(range_reg));
        if (going_up) begin
          going_up = cur_angle < upper;
        end else begin
          going_up = cur_angle <= lower;
        end
        step = going_up ? 1 : -1;
      end
      if (step != 0) cur_angle = limit_angle(cur_angle + step);
      r.position      = cur_angle[AngleW-1:0];
      r.moved         = (step != 0);
      r.reached_event = ev;
      r.reached_code  = ev ? goal_code : '0;
      pending_results.push_back(r);
    endfunction

    function void compare_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: position %0d", got.position);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        mismatches++;
      end
      if (got.moved !== want.moved) begin
        $error("moved: expected %0d, actual %0d", want.moved, got.moved);
        mismatches++;
      end
      if (got.reached_event !== want.reached_event) begin
        $error("reached_event: expected %0d, actual %0d",
               want.reached_event, got.reached_event);
        mismatches++;
      end
      if (got.reached_code !== want.reached_code) begin
        $error("reached_code: expected %0d, actual %0d",
               want.reached_code, got.reached_code);
        mismatches++;
      end
      if (want.reached_event) events_seen++;
    endfunction
  endclass

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                cmd_op       = 1'b0;
  logic [CodeW-1:0]    cmd_sel      = '0;
  logic                cmd_osc      = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [AngleW-1:0]   position;
  logic                moved;
  logic                reached_event;
  logic [CodeW-1:0]    reached_code;

  bit                  no_gaps      = 1'b0;
  bit                  hold_request = 1'b0;
  int unsigned         idle_cycles  = 0;

  angle_tracker tracker = new();

  servo_slew_and_oscillate_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (cmd_op),
    .target_select_i (cmd_sel),
    .oscillate_i     (cmd_osc),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .position_o      (position),
    .moved_o         (moved),
    .reached_event_o (reached_event),
    .reached_code_o  (reached_code)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Ends the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: random stall per transaction, plus one long hold on request.
  initial begin
    int   wait_cycles;
    res_t got;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall    = 1'b1;
        repeat (LongHold) @(negedge clk);
      end
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 4);
      if (wait_cycles > 0) begin
        out_stall = 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{position: position, moved: moved, reached_event: reached_event,
              reached_code: reached_code};
      tracker.compare_result(got);
    end
  end

  // Starts and ends at a falling edge; valid stays high into the next call.
  task automatic send_item(op_e op, logic [CodeW-1:0] sel, logic osc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_op   = op;
    cmd_sel  = sel;
    cmd_osc  = osc;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.accept_command(op, sel, osc);
    @(negedge clk);
  endtask

  task automatic tick(int n);
    repeat (n) send_item(OP_TICK, TGT_FWD, 1'b0);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.write_reg(idx, data);
  endtask

  task automatic set_config(int center, int fwd, int look, int range, int step);
    wait_idle();
    cfg_write(CFG_CENTER, center[CfgDataW-1:0]);
    cfg_write(CFG_FWD_OFF, fwd[CfgDataW-1:0]);
    cfg_write(CFG_LOOK_OFF, look[CfgDataW-1:0]);
    cfg_write(CFG_OSC_RANGE, range[CfgDataW-1:0]);
    cfg_write(CFG_STEP, step[CfgDataW-1:0]);
  endtask

  // Mostly ticks; now and then a new look target, sometimes an unknown code.
  task automatic run_phase(int n_items, int set_pct);
    logic [CodeW-1:0] sel;
    logic             osc;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < set_pct) begin
        sel = ($urandom_range(0, 9) == 0) ? CodeW'($urandom_range(5, 7))
                                          : CodeW'($urandom_range(0, 4));
        osc = ($urandom_range(0, 9) < 7);
        send_item(OP_SET, sel, osc);
      end else begin
        send_item(OP_TICK, CodeW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int center;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // register defaults: idle tick, then a target equal to the start position
    tick(1);
    send_item(OP_SET, TGT_FWD, 1'b0);
    tick(2);

    // large step jumps straight to each target, narrow sweep afterward
    wait_idle();
    cfg_write(CFG_STEP, 8'd180);
    cfg_write(CFG_OSC_RANGE, 8'd1);
    send_item(OP_SET, TGT_FWD_LEFT, 1'b1);
    tick(5);
    send_item(OP_SET, TGT_FWD_RIGHT, 1'b0);
    tick(2);
    send_item(OP_SET, TGT_LEFT, 1'b1);
    tick(3);
    send_item(OP_SET, TGT_RIGHT, 1'b0);
    tick(2);
    send_item(OP_SET, 3'd7, 1'b0);  // unknown code acts as forward
    tick(2);

    // extremes: zero offsets, zero range, zero step
    set_config(0, 0, 0, 0, 0);
    run_phase(120, 10);
    set_config(180, 127, 127, 127, 255);
    run_phase(120, 10);
    // center above the angle range, with the long output hold
    set_config(255, 90, 90, 90, 180);
    hold_request = 1'b1;
    run_phase(120, 10);

    for (int p = 0; p < 5; p++) begin
      center = ($urandom_range(0, 7) == 0) ? $urandom_range(181, 255) : $urandom_range(0, 180);
      set_config(center, $urandom_range(0, 127), $urandom_range(0, 127),
                 $urandom_range(0, 15),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
      no_gaps = (p == 2);
      run_phase(130, 5);
    end
    no_gaps = 1'b0;

    wait_idle();
    repeat (10) @(negedge clk);
    $display("summary: %0d commands, %0d results checked, %0d reached events, %0d reg writes",
             tracker.commands, tracker.checked, tracker.events_seen, tracker.reg_writes);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> servo_slew_and_oscillate_core.f
design/sso_pkg.sv
design/sso_cfg_regs.sv
design/sso_step.sv
design/servo_slew_and_oscillate_core.sv
design/sso_checker.sv
tb/sv/servo_slew_and_oscillate_core_test.sv
